>>> rtl/tsp_pkg.sv
// Shared types and constants for the touch slider position block.
package tsp_pkg;

    localparam int MaxElectrodes = 16;
    localparam int IdxW          = $clog2(MaxElectrodes);

    typedef enum logic [1:0] {
        REG_ELECTRODE_COUNT = 2'd0,
        REG_SLIDER_LENGTH   = 2'd1,
        REG_TOUCH_THRESHOLD = 2'd2
    } t_reg_idx;

    // Word passed from the front part to the back part.
    typedef struct packed {
        logic [IdxW-1:0] next_electrode;
        logic [15:0]     scan_delta;
        logic            touched;
        logic [15:0]     d0;
        logic [15:0]     d1;
        logic [7:0]      length;
    } t_job;

endpackage

>>> rtl/tsp_front.sv
// Front part: baseline and delta stores, electrode sequencing, touch test.
module tsp_front
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  logic        i_op,
    input  logic [15:0] i_raw_count,
    output t_job        o_job
);

    logic [4:0]      r_count;
    logic [7:0]      r_length;
    logic [15:0]     r_threshold;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [15:0]     r_base  [MaxElectrodes];
    logic [15:0]     r_delta [MaxElectrodes];
    logic [16:0]     diff;
    logic [15:0]     sdelta, d0, d1;
    logic [4:0]      cnt;

    assign diff   = {1'b0, i_raw_count} - {1'b0, r_base[r_idx]};
    assign sdelta = i_op ? 16'd0 : (diff[16] ? 16'd0 : diff[15:0]);
    assign cnt    = (r_count > 5'(MaxElectrodes)) ? 5'(MaxElectrodes) : r_count;

    always_comb begin
        n_idx = r_idx;
        if (cnt > 5'd1) begin
            if (cnt - 5'd1 > 5'(r_idx)) n_idx = r_idx + 1'b1;
            else                         n_idx = '0;
        end
    end

    // Deltas of electrodes 0 and 1 as they stand after this word.
    assign d0 = (!i_op && r_idx == '0) ? sdelta : r_delta[0];
    assign d1 = (!i_op && r_idx == IdxW'(1)) ? sdelta : r_delta[1];

    always_comb begin
        o_job.next_electrode = n_idx;
        o_job.scan_delta     = sdelta;
        o_job.touched        = (d0 > r_threshold) || (d1 > r_threshold);
        o_job.d0             = d0;
        o_job.d1             = d1;
        o_job.length         = r_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 5'd2;
            r_length    <= 8'd40;
            r_threshold <= 16'd100;
            r_idx       <= '0;
            for (int i = 0; i < MaxElectrodes; i++) begin
                r_base[i]  <= '0;
                r_delta[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ELECTRODE_COUNT: r_count     <= i_cfg_data[4:0];
                    REG_SLIDER_LENGTH:   r_length    <= i_cfg_data[7:0];
                    REG_TOUCH_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push) begin
                if (i_op) r_base[r_idx]  <= i_raw_count;
                else      r_delta[r_idx] <= sdelta;
                r_idx <= n_idx;
            end
        end
    end

endmodule

>>> rtl/tsp_back.sv
// Back part: serial divider for the percentages, then the distances.
module tsp_back
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_job        i_job,
    output logic        o_busy,
    output logic        o_done,
    output logic [IdxW-1:0] o_next_electrode,
    output logic [15:0] o_scan_delta,
    output logic        o_touched,
    output logic [6:0]  o_left_percent,
    output logic [6:0]  o_right_percent,
    output logic [7:0]  o_left_distance,
    output logic [7:0]  o_right_distance,
    output logic [6:0]  o_position_percent,
    output logic [7:0]  o_position_distance
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCL  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state       r_state;
    t_job         r_job;
    logic [23:0]  r_num;     // d0*100, shifted out msb first
    logic [16:0]  r_sum;
    logic [17:0]  r_rem;
    logic [6:0]   r_quo;
    logic [4:0]   r_cnt;
    logic [6:0]   r_lp, r_rp;
    logic [14:0]  r_lm, r_rm;
    logic [17:0]  trial_rem;
    logic [17:0]  sub;
    logic [6:0]   rp_c;
    logic [7:0]   ld, rd;
    logic [8:0]   psum;
    logic [9:0]   dsum;

    assign trial_rem = {r_rem[16:0], r_num[23]};
    assign sub       = trial_rem - {1'b0, r_sum};
    // rp = 100 - lp, less one when the remainder of the left share is nonzero.
    assign rp_c      = (r_job.d1 == '0) ? 7'd0 :
                       ((r_job.d0 == '0) ? 7'd100 :
                        (7'd100 - r_quo - ((r_rem != '0) ? 7'd1 : 7'd0)));
    // x/100 for x < 25600 via reciprocal 655/65536 plus a correction.
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [24:0] p;
        logic [7:0]  q;
        logic [15:0] r;
        p = 25'(x) * 25'd655;
        q = p[23:16];
        r = 16'(x) - 16'(q) * 16'd100;
        if (r >= 16'd100) q = q + 8'd1;
        return q;
    endfunction

    assign ld   = div100(r_lm);
    assign rd   = div100(r_rm);
    assign psum = 9'd100 - 9'(r_lp) + 9'(r_rp);
    assign dsum = 10'(r_job.length) - 10'(ld) + 10'(rd);

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_job   <= i_job;
                        r_num   <= 24'(i_job.d0) * 24'd100;
                        r_sum   <= 17'(i_job.d0) + 17'(i_job.d1);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 5'd24;
                        r_state <= i_job.touched ? S_DIV : S_FIN;
                        r_lp    <= '0;
                        r_rp    <= '0;
                        r_lm    <= '0;
                        r_rm    <= '0;
                    end
                end
                S_DIV: begin
                    if (!sub[17]) begin
                        r_rem <= sub;
                        r_quo <= {r_quo[5:0], 1'b1};
                    end else begin
                        r_rem <= trial_rem;
                        r_quo <= {r_quo[5:0], 1'b0};
                    end
                    r_num <= {r_num[22:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) r_state <= S_SCL;
                end
                S_SCL: begin
                    r_lp    <= r_quo;
                    r_rp    <= rp_c;
                    r_lm    <= 15'(r_quo) * 15'(r_job.length);
                    r_rm    <= 15'(rp_c) * 15'(r_job.length);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_next_electrode    <= r_job.next_electrode;
                    o_scan_delta        <= r_job.scan_delta;
                    o_touched           <= r_job.touched;
                    o_left_percent      <= r_lp;
                    o_right_percent     <= r_rp;
                    o_left_distance     <= ld;
                    o_right_distance    <= rd;
                    o_position_percent  <= r_job.touched ? psum[7:1] : 7'd0;
                    o_position_distance <= r_job.touched ? dsum[8:1] : 8'd0;
                    o_done              <= 1'b1;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_done_after_fin;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_FIN) |=> o_done;
    endproperty
    a_done_after_fin: assert property (p_done_after_fin) else $error("done missing");

    property p_no_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(o_busy) |-> $past(i_start);
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("busy without start");

    property p_pct_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_done |-> (o_left_percent <= 7'd100 && o_right_percent <= 7'd100);
    endproperty
    a_pct_range: assert property (p_pct_range) else $error("percent over 100");

endmodule

>>> rtl/touch_slider_position.sv
// Top level of the two-electrode capacitive touch slider position block.
// An untouched word goes straight to the finish state; a touched one first passes through
//   a 24-step restoring divider for the left share and then a scaling state.
// The back takes no new word until it has finished the last one and its result slot is free.
// Reset: synchronous active low; stores, index, config registers and state flags take reset values.
// The front holds one word while the back divides; the output is a one-deep queue.
module touch_slider_position
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [15:0] i_raw_count,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_next_electrode,
    output logic [15:0] o_scan_delta,
    output logic        o_touched,
    output logic [6:0]  o_left_percent,
    output logic [6:0]  o_right_percent,
    output logic [7:0]  o_left_distance,
    output logic [7:0]  o_right_distance,
    output logic [6:0]  o_position_percent,
    output logic [7:0]  o_position_distance
);

    t_job  job;
    t_job  r_q;            // queue slot between front and back
    logic  r_q_valid;
    logic  r_out_valid;
    logic  back_busy, back_done, start, push_ok;
    logic [IdxW-1:0] b_next;
    logic [15:0] b_delta;
    logic        b_touched;
    logic [6:0]  b_lp, b_rp, b_pp;
    logic [7:0]  b_ld, b_rd, b_pd;

    assign o_cfg_ready = 1'b1;
    assign o_full      = r_q_valid;
    assign push_ok     = i_push && !r_q_valid;
    // Start the back only when its result slot is free and no finished word is landing in it.
    assign start       = r_q_valid && !back_busy && !back_done && !r_out_valid;
    assign o_empty     = !r_out_valid;

    tsp_front u_front (
        .i_clk, .i_rst_n,
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push_ok),
        .i_op        (i_op),
        .i_raw_count (i_raw_count),
        .o_job       (job)
    );

    tsp_back u_back (
        .i_clk, .i_rst_n,
        .i_start             (start),
        .i_job               (r_q),
        .o_busy              (back_busy),
        .o_done              (back_done),
        .o_next_electrode    (b_next),
        .o_scan_delta        (b_delta),
        .o_touched           (b_touched),
        .o_left_percent      (b_lp),
        .o_right_percent     (b_rp),
        .o_left_distance     (b_ld),
        .o_right_distance    (b_rd),
        .o_position_percent  (b_pp),
        .o_position_distance (b_pd)
    );

    assign o_next_electrode    = b_next;
    assign o_scan_delta        = b_delta;
    assign o_touched           = b_touched;
    assign o_left_percent      = b_lp;
    assign o_right_percent     = b_rp;
    assign o_left_distance     = b_ld;
    assign o_right_distance    = b_rd;
    assign o_position_percent  = b_pp;
    assign o_position_distance = b_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the word until the back takes it.
            if (push_ok)    r_q_valid <= 1'b1;
            else if (start) r_q_valid <= 1'b0;
            if (back_done)                   r_out_valid <= 1'b1;
            else if (i_pop && r_out_valid)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q <= job;
    end

    property p_done_slot_free;
        @(posedge i_clk) disable iff (!i_rst_n) back_done |-> !r_out_valid;
    endproperty
    a_done_slot_free: assert property (p_done_slot_free) else $error("result overwrite");

    property p_start_has_word;
        @(posedge i_clk) disable iff (!i_rst_n) start |=> back_busy;
    endproperty
    a_start_has_word: assert property (p_start_has_word) else $error("start lost");

    property p_push_fills;
        @(posedge i_clk) disable iff (!i_rst_n) push_ok |=> r_q_valid;
    endproperty
    a_push_fills: assert property (p_push_fills) else $error("queue slot lost");

endmodule

>>> test/tsp_checker.sv
// Checker for the touch slider block: tracks config, predicts slider words, compares results.
`timescale 1ns / 1ps
module tsp_checker
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_op,
    input  logic [15:0] i_raw_count,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [3:0]  i_next_electrode,
    input  logic [15:0] i_scan_delta,
    input  logic        i_touched,
    input  logic [6:0]  i_left_percent,
    input  logic [6:0]  i_right_percent,
    input  logic [7:0]  i_left_distance,
    input  logic [7:0]  i_right_distance,
    input  logic [6:0]  i_position_percent,
    input  logic [7:0]  i_position_distance,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0]  next_electrode;
        logic [15:0] scan_delta;
        logic        touched;
        logic [6:0]  left_percent;
        logic [6:0]  right_percent;
        logic [7:0]  left_distance;
        logic [7:0]  right_distance;
        logic [6:0]  position_percent;
        logic [7:0]  position_distance;
    } t_slider_word;

    logic [4:0]  m_count;
    logic [7:0]  m_length;
    logic [15:0] m_threshold;
    logic [3:0]  m_index;
    logic [15:0] m_baseline [16];
    logic [15:0] m_delta    [16];
    t_slider_word slider_q [$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = slider_q.size();

    // Apply one scan or calibrate word to the model state and build its result.
    function automatic t_slider_word slider_predict(logic op, logic [15:0] raw);
        t_slider_word w;
        logic [3:0] idx;
        int cnt, d0, d1, sum, len;
        w = '0;
        idx = m_index;
        if (op) begin
            m_baseline[idx] = raw;
        end else begin
            w.scan_delta = (raw > m_baseline[idx]) ? raw - m_baseline[idx] : 16'd0;
            m_delta[idx] = w.scan_delta;
        end
        cnt = (m_count > MaxElectrodes) ? MaxElectrodes : int'(m_count);
        if (cnt > 1) begin
            m_index = (cnt - 1 > int'(idx)) ? idx + 4'd1 : 4'd0;
        end
        w.next_electrode = m_index;
        d0 = int'(m_delta[0]);
        d1 = int'(m_delta[1]);
        if (d0 > int'(m_threshold) || d1 > int'(m_threshold)) begin
            sum = d0 + d1;
            len = int'(m_length);
            w.touched = 1'b1;
            w.left_percent  = 7'((d0 * 100) / sum);
            w.right_percent = 7'((d1 * 100) / sum);
            w.left_distance  = 8'((int'(w.left_percent) * len) / 100);
            w.right_distance = 8'((int'(w.right_percent) * len) / 100);
            w.position_percent = 7'(((100 - int'(w.left_percent))
                                     + int'(w.right_percent)) / 2);
            w.position_distance = 8'(((len - int'(w.left_distance))
                                      + int'(w.right_distance)) / 2);
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_slider_word got, exp_w;
        if (!i_rst_n) begin
            m_count = 5'd2;
            m_length = 8'd40;
            m_threshold = 16'd100;
            m_index = '0;
            for (int i = 0; i < 16; i++) begin
                m_baseline[i] = '0;
                m_delta[i] = '0;
            end
            slider_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ELECTRODE_COUNT: m_count = i_cfg_data[4:0];
                    REG_SLIDER_LENGTH:   m_length = i_cfg_data[7:0];
                    REG_TOUCH_THRESHOLD: m_threshold = i_cfg_data;
                    default: ;
                endcase
            end
            // Check the result before predicting, so a same-edge push cannot be matched.
            if (i_pop && !i_empty) begin
                got = {i_next_electrode, i_scan_delta, i_touched, i_left_percent,
                       i_right_percent, i_left_distance, i_right_distance,
                       i_position_percent, i_position_distance};
                if (slider_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %h", got);
                end else begin
                    exp_w = slider_q.pop_front();
                    if (got !== exp_w) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p actual %p", exp_w, got);
                    end
                end
            end
            if (i_push && !i_full) slider_q.push_back(slider_predict(i_op, i_raw_count));
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench top: drives stimulus and config into the slider block and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
    import tsp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic        op = 1'b0;
    logic [15:0] raw_count = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  next_electrode;
    logic [15:0] scan_delta;
    logic        touched;
    logic [6:0]  left_percent, right_percent, position_percent;
    logic [7:0]  left_distance, right_distance, position_distance;
    int          fail_count, pending;
    int          send_idle = 0, recv_idle = 0;
    int          quiet_cycles = 0;
    localparam int WatchdogLimit = 5000;

    always #2 i_clk = ~i_clk;

    touch_slider_position i_dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_push(push), .o_full(full), .i_op(op), .i_raw_count(raw_count),
        .o_empty(empty), .i_pop(pop),
        .o_next_electrode(next_electrode), .o_scan_delta(scan_delta),
        .o_touched(touched), .o_left_percent(left_percent),
        .o_right_percent(right_percent), .o_left_distance(left_distance),
        .o_right_distance(right_distance), .o_position_percent(position_percent),
        .o_position_distance(position_distance)
    );

    tsp_checker i_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_push(push), .i_full(full), .i_op(op), .i_raw_count(raw_count),
        .i_empty(empty), .i_pop(pop),
        .i_next_electrode(next_electrode), .i_scan_delta(scan_delta),
        .i_touched(touched), .i_left_percent(left_percent),
        .i_right_percent(right_percent), .i_left_distance(left_distance),
        .i_right_distance(right_distance), .i_position_percent(position_percent),
        .i_position_distance(position_distance),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: drop pop at random, per the current idle percentage.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: count cycles with no accepted word on any channel.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("[touch_slider_position] ERROR");
            $finish;
        end
    end

    // Push one word; hold it until accepted, optionally idling first.
    // Push stays high after acceptance so back-to-back words need one drive per edge.
    task automatic send_word(logic w_op, logic [15:0] w_raw);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        op <= w_op;
        raw_count <= w_raw;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off until every expected word has drained, plus a margin longer than the touched latency.
    task automatic drain_results();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly touch-like traffic: a random mix of calibrates and scans near 0x8000 with random offsets.
    task automatic random_phase(int n);
        logic [15:0] r;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: r = 16'($urandom());
                1: r = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: r = 16'(16'h8000 + $urandom_range(600) - 200);
            endcase
            send_word(($urandom_range(7) == 0), r);
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: extremes, zero deltas, wrap-free difference, touch on either side.
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'hFFFF);
        send_word(1'b0, 16'd50);
        send_word(1'b0, 16'd0);
        send_word(1'b1, 16'h8000);
        send_word(1'b0, 16'd200);
        send_word(1'b0, 16'h8100);
        send_word(1'b0, 16'd150);
        write_reg(REG_TOUCH_THRESHOLD, 16'd0);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'h8001);
        write_reg(REG_TOUCH_THRESHOLD, 16'hFFFF);
        send_word(1'b0, 16'hFFFF);
        write_reg(REG_SLIDER_LENGTH, 16'd255);
        write_reg(REG_TOUCH_THRESHOLD, 16'd5);
        send_word(1'b0, 16'd77);
        send_word(1'b0, 16'h80FF);
        write_reg(REG_SLIDER_LENGTH, 16'd1);
        send_word(1'b0, 16'd30);
        // Count of one holds the index; count over the maximum saturates.
        write_reg(REG_ELECTRODE_COUNT, 16'd1);
        send_word(1'b0, 16'd400);
        send_word(1'b0, 16'd10);
        write_reg(REG_ELECTRODE_COUNT, 16'd31);
        send_word(1'b0, 16'd500);
        send_word(1'b1, 16'd5);
        write_reg(REG_ELECTRODE_COUNT, 16'd0);
        send_word(1'b0, 16'd3);

        // Random phases under three idling profiles and several settings.
        send_idle = 11; recv_idle = 75;
        write_reg(REG_ELECTRODE_COUNT, 16'd2);
        write_reg(REG_SLIDER_LENGTH, 16'd40);
        write_reg(REG_TOUCH_THRESHOLD, 16'd100);
        random_phase(300);
        write_reg(REG_ELECTRODE_COUNT, 16'd16);
        write_reg(REG_SLIDER_LENGTH, 16'd255);
        random_phase(150);
        send_idle = 75; recv_idle = 11;
        write_reg(REG_ELECTRODE_COUNT, 16'd3);
        write_reg(REG_TOUCH_THRESHOLD, 16'd0);
        write_reg(REG_SLIDER_LENGTH, 16'd1);
        random_phase(300);
        send_idle = 0; recv_idle = 0;
        write_reg(REG_ELECTRODE_COUNT, 16'd2);
        write_reg(REG_SLIDER_LENGTH, 16'($urandom_range(255, 1)));
        write_reg(REG_TOUCH_THRESHOLD, 16'($urandom_range(400)));
        random_phase(300);
        write_reg(REG_TOUCH_THRESHOLD, 16'hFFFF);
        random_phase(200);

        drain_results();
        if (fail_count == 0)
            $display("[touch_slider_position] OK");
        else
            $display("[touch_slider_position] ERROR");
        $finish;
    end

endmodule
